[sv/tfp_pkg.sv]
// tank fill policy package: command codes, tiers, modes, fsm states
// no dependencies
package tfp_pkg;

  localparam int unsigned MinFillSeconds    = 60;
  localparam int unsigned BackupFillSeconds = 600;
  localparam int unsigned EstWidth          = 20;

  localparam logic [1:0] CMD_LEVEL  = 2'd0;
  localparam logic [1:0] CMD_MANUAL = 2'd1;
  localparam logic [1:0] CMD_PUMP   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] PUMP_IDLE    = 2'd0;
  localparam logic [1:0] PUMP_RUNNING = 2'd1;
  localparam logic [1:0] PUMP_UNKNOWN = 2'd3;

  localparam logic [2:0] TIER_NONE    = 3'd0;
  localparam logic [2:0] TIER_CRIT    = 3'd1;
  localparam logic [2:0] TIER_NORMAL  = 3'd2;
  localparam logic [2:0] TIER_OPP     = 3'd3;
  localparam logic [2:0] TIER_SURPLUS = 3'd4;
  localparam logic [2:0] TIER_MANUAL  = 3'd5;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_REQ  = 2'd1;
  localparam logic [1:0] MODE_FILL = 2'd2;

  localparam logic [2:0] REG_FULL     = 3'd0;
  localparam logic [2:0] REG_CRIT     = 3'd1;
  localparam logic [2:0] REG_NORMAL   = 3'd2;
  localparam logic [2:0] REG_OPP      = 3'd3;
  localparam logic [2:0] REG_SURPLUS  = 3'd4;
  localparam logic [2:0] REG_COOLDOWN = 3'd5;
  localparam logic [2:0] REG_WINDOW   = 3'd6;
  localparam logic [2:0] REG_RATE     = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic out_load;
  } tfp_cmd_t;

  typedef struct packed {
    logic div_done;
  } tfp_sts_t;

  typedef struct packed {
    logic [9:0] full_level;
    logic [9:0] critical_level;
    logic [9:0] normal_level;
    logic [9:0] opportunistic_level;
    logic [9:0] surplus_level;
    logic [16:0] cooldown_seconds;
    logic [10:0] sunset_window_minutes;
    logic [15:0] fill_rate_tenths;
  } tfp_cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic [9:0] level_permille;
    logic float_full;
    logic sensor_fault;
    logic [1:0] pump_state;
    logic [31:0] now_seconds;
    logic is_day;
    logic signed [11:0] minutes_to_sunset;
  } tfp_in_t;

  typedef struct packed {
    logic [1:0] fill_state;
    logic [2:0] fill_tier;
    logic want_pump_on;
    logic [1:0] urgency;
    logic [1:0] supply_pref;
    logic [19:0] estimated_seconds;
  } tfp_out_t;

endpackage

[sv/tfp_if.sv]
// valid/ready channel interface carrying one payload
// no package dependency: the payload type is a parameter
interface tfp_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/tfp_cfg.sv]
// configuration register file behind the apb-style port
// depends on tfp_pkg
module tfp_cfg import tfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output tfp_cfg_t    cfg
);
  tfp_cfg_t cfg_r;
  logic [2:0] idx;

  assign idx = paddr[4:2];
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_level <= 10'd950;
      cfg_r.critical_level <= 10'd300;
      cfg_r.normal_level <= 10'd500;
      cfg_r.opportunistic_level <= 10'd800;
      cfg_r.surplus_level <= 10'd900;
      cfg_r.cooldown_seconds <= 17'd3600;
      cfg_r.sunset_window_minutes <= 11'd120;
      cfg_r.fill_rate_tenths <= 16'd50;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_FULL:     cfg_r.full_level <= pwdata[9:0];
        REG_CRIT:     cfg_r.critical_level <= pwdata[9:0];
        REG_NORMAL:   cfg_r.normal_level <= pwdata[9:0];
        REG_OPP:      cfg_r.opportunistic_level <= pwdata[9:0];
        REG_SURPLUS:  cfg_r.surplus_level <= pwdata[9:0];
        REG_COOLDOWN: cfg_r.cooldown_seconds <= pwdata[16:0];
        REG_WINDOW:   cfg_r.sunset_window_minutes <= pwdata[10:0];
        REG_RATE:     cfg_r.fill_rate_tenths <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FULL:     prdata = {22'd0, cfg_r.full_level};
      REG_CRIT:     prdata = {22'd0, cfg_r.critical_level};
      REG_NORMAL:   prdata = {22'd0, cfg_r.normal_level};
      REG_OPP:      prdata = {22'd0, cfg_r.opportunistic_level};
      REG_SURPLUS:  prdata = {22'd0, cfg_r.surplus_level};
      REG_COOLDOWN: prdata = {15'd0, cfg_r.cooldown_seconds};
      REG_WINDOW:   prdata = {21'd0, cfg_r.sunset_window_minutes};
      REG_RATE:     prdata = {16'd0, cfg_r.fill_rate_tenths};
      default:      prdata = 32'd0;
    endcase
  end
endmodule

[sv/tfp_ctrl.sv]
// controller state machine: accept request, run divider, present result
// depends on tfp_pkg
module tfp_ctrl import tfp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  tfp_sts_t sts,
  output tfp_cmd_t cmd
);
  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    cmd.div_start = cmd.load;
  end
endmodule

[sv/tfp_dp.sv]
// datapath: policy state, tier evaluation, restoring divider, result register
// depends on tfp_pkg
module tfp_dp import tfp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tfp_cfg_t cfg,
  input  tfp_in_t  req,
  input  tfp_cmd_t cmd,
  output tfp_sts_t sts,
  output tfp_out_t res
);
  logic [9:0]  level_r;
  logic        float_r, backup_r, running_r, manual_r;
  logic [31:0] deadline_r;
  logic [2:0]  tier_r;
  logic [1:0]  mode_r;
  logic        day_r;

  // next-state evaluation of policy state
  logic [9:0]  lvl_n;
  logic        flt_n, bak_n, run_n, man_n;
  logic [31:0] dl_n;
  logic [2:0]  tier_n, t;
  logic [1:0]  mode_n;
  logic        full_pre, full_n, window, cool, upd;
  logic [9:0]  tgt_t;

  function automatic logic [9:0] target_of(input logic [2:0] tr, input tfp_cfg_t c,
                                            input logic [9:0] lv);
    case (tr)
      TIER_CRIT:    target_of = c.normal_level;
      TIER_NORMAL:  target_of = c.opportunistic_level;
      TIER_OPP:     target_of = c.surplus_level;
      TIER_SURPLUS: target_of = c.full_level;
      TIER_MANUAL:  target_of = c.full_level;
      default:      target_of = lv;
    endcase
  endfunction

  always_comb begin
    lvl_n = level_r; flt_n = float_r; bak_n = backup_r;
    run_n = running_r; man_n = manual_r; dl_n = deadline_r;
    upd = 1'b1;
    full_pre = backup_r ? float_r : (level_r >= cfg.full_level);
    case (req.command)
      CMD_LEVEL: begin
        lvl_n = req.level_permille; flt_n = req.float_full; bak_n = req.sensor_fault;
      end
      CMD_MANUAL: begin
        man_n = 1'b1; dl_n = 32'd0;
      end
      CMD_PUMP: begin
        run_n = (req.pump_state == PUMP_RUNNING);
        if (running_r && !run_n) begin
          man_n = 1'b0;
          if (req.pump_state == PUMP_IDLE && !full_pre)
            dl_n = req.now_seconds + {15'd0, cfg.cooldown_seconds};
        end
      end
      default: upd = 1'b0;
    endcase
    full_n = bak_n ? flt_n : (lvl_n >= cfg.full_level);
    window = req.is_day && !req.minutes_to_sunset[11] && (req.minutes_to_sunset != 12'sd0)
             && ({1'b0, req.minutes_to_sunset[10:0]} <= {1'b0, cfg.sunset_window_minutes});
    cool = (dl_n != 32'd0) && (req.now_seconds < dl_n);
    if (man_n) t = TIER_MANUAL;
    else if (bak_n) t = flt_n ? TIER_NONE : TIER_NORMAL;
    else if (lvl_n < cfg.critical_level) t = TIER_CRIT;
    else if (cool) t = TIER_NONE;
    else if (!req.is_day) t = TIER_NONE;
    else if (window && lvl_n < cfg.opportunistic_level) t = TIER_OPP;
    else if (lvl_n < cfg.normal_level) t = TIER_NORMAL;
    else if (lvl_n < cfg.opportunistic_level) t = TIER_OPP;
    else if (lvl_n < cfg.surplus_level) t = TIER_SURPLUS;
    else t = TIER_NONE;
    tgt_t = target_of(t, cfg, lvl_n);
    tier_n = tier_r; mode_n = mode_r;
    if (upd) begin
      if (full_n) begin
        tier_n = TIER_NONE; mode_n = MODE_IDLE; man_n = 1'b0;
      end else begin
        if (t != TIER_NONE && !bak_n && lvl_n >= tgt_t) tier_n = TIER_NONE;
        else tier_n = t;
        mode_n = (tier_n == TIER_NONE) ? MODE_IDLE : (run_n ? MODE_FILL : MODE_REQ);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0; float_r <= 1'b0; backup_r <= 1'b0; running_r <= 1'b0;
      manual_r <= 1'b0; deadline_r <= '0; tier_r <= TIER_NONE; mode_r <= MODE_IDLE;
    end else if (cmd.load) begin
      level_r <= lvl_n; float_r <= flt_n; backup_r <= bak_n; running_r <= run_n;
      manual_r <= man_n; deadline_r <= dl_n; tier_r <= tier_n; mode_r <= mode_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) day_r <= req.is_day;
  end

  // restoring divider: dividend = deficit * 600 (20 bits), divisor = rate
  logic [9:0]  tgt_s;
  logic [9:0]  deficit;
  logic [19:0] dividend;
  logic [25:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] rem_sh, rem_sub;
  logic [4:0]  cnt_r, cnt_nxt;

  assign tgt_s = target_of(tier_r, cfg, level_r);
  assign deficit = tgt_s - level_r;
  assign dividend = {10'd0, deficit} * 20'd600;

  always_comb begin
    rem_sh = {rem_r[15:0], quo_r[25]};
    rem_sub = rem_sh - {1'b0, cfg.fill_rate_tenths};
    quo_nxt = quo_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    if (cmd.div_step) begin
      if (!rem_sub[16]) begin
        rem_nxt = rem_sub; quo_nxt = {quo_r[24:0], 1'b1};
      end else begin
        rem_nxt = rem_sh; quo_nxt = {quo_r[24:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
    end
  end

  // first step after load starts with cleared state; dividend sampled then
  logic first_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0; cnt_r <= '0;
    end else if (cmd.div_start) begin
      first_r <= 1'b1; cnt_r <= '0;
    end else if (first_r) begin
      first_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (first_r) begin
      quo_r <= {dividend, 6'd0}; rem_r <= '0;
    end else begin
      quo_r <= quo_nxt; rem_r <= rem_nxt;
    end
  end

  assign sts.div_done = !first_r && (cnt_r == 5'(EstWidth - 1)) && cmd.div_step;

  // quotient is in low 20 bits of quo after 20 steps (top 6 zero bits unused)
  logic [19:0] quot;
  logic [19:0] dur;
  assign quot = quo_nxt[19:0];

  always_comb begin
    if (backup_r) dur = float_r ? 20'd0 : 20'(BackupFillSeconds);
    else if (tier_r == TIER_NONE) dur = 20'd0;
    else if (level_r >= tgt_s || cfg.fill_rate_tenths == 16'd0) dur = 20'd0;
    else if (quot < 20'(MinFillSeconds)) dur = 20'(MinFillSeconds);
    else dur = quot;
  end

  tfp_out_t res_r, res_nxt;
  logic [19:0] dur_r;
  always_ff @(posedge clk) begin
    if (sts.div_done) dur_r <= dur;
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.fill_state = mode_r;
    res_nxt.fill_tier = tier_r;
    if (mode_r != MODE_IDLE && tier_r != TIER_NONE && dur_r != 20'd0) begin
      res_nxt.want_pump_on = 1'b1;
      res_nxt.estimated_seconds = dur_r;
      case (tier_r)
        TIER_CRIT:    begin res_nxt.urgency = 2'd3; res_nxt.supply_pref = 2'd2; end
        TIER_MANUAL:  begin
          res_nxt.urgency = 2'd2;
          res_nxt.supply_pref = day_r ? 2'd1 : 2'd2;
        end
        TIER_NORMAL:  begin res_nxt.urgency = 2'd2; res_nxt.supply_pref = 2'd1; end
        TIER_OPP:     begin res_nxt.urgency = 2'd1; res_nxt.supply_pref = 2'd1; end
        TIER_SURPLUS: begin res_nxt.urgency = 2'd1; res_nxt.supply_pref = 2'd0; end
        default: begin
          res_nxt.want_pump_on = 1'b0; res_nxt.estimated_seconds = 20'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) res_r <= res_nxt;
  end

  assign res = res_r;
endmodule

[sv/tank_fill_policy.sv]
// tank fill policy top level: apb config, request and result channels
// a request passes from accept through setup, 20 divider steps and the result load to result valid
// one request at a time: no new request is accepted while the divider runs or a result waits to load
// reset: rst_n synchronous active low; clears policy state, loads register defaults
module tank_fill_policy import tfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  tfp_if.sink         in_ch,
  tfp_if.source       out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  tfp_cfg_t cfg;
  tfp_cmd_t cmd;
  tfp_sts_t sts;

  tfp_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  tfp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  tfp_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .req(in_ch.data), .cmd(cmd),
    .sts(sts), .res(out_ch.data)
  );
endmodule
